>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME(label, clock, resetn, ante, cons)
`define ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

>>> hdl/fiw_pkg.sv
// ----------------------------------------------------------------------------
// Flash image writer package
// Widths, codes, transfer payload types and the CRC-32 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fiw_pkg;

    localparam int SIZE_W  = 25;
    localparam int UNIT_W  = 17;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = $clog2(SIZE_W);
    localparam int INDEX_W = 2;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_XOR  = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ARGS  = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_ORDER = 3'd3;
    localparam logic [2:0] ST_IO    = 3'd4;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_HEADER = 2'd3;

    localparam logic [INDEX_W-1:0] REG_FLASH_SIZE  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SECTOR_SIZE = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAGIC       = 2'd2;

    localparam logic [SIZE_W-1:0] FLASH_SIZE_RST  = 25'd4194304;
    localparam logic [UNIT_W-1:0] SECTOR_SIZE_RST = 17'd4096;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] image_size;
        logic [BYTE_W-1:0] data_byte;
        logic              io_failed;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        flash_op;
        logic [SIZE_W-1:0] flash_address;
        logic [SIZE_W-1:0] erase_length;
        logic [BYTE_W-1:0] write_byte;
        logic [WORD_W-1:0] header_magic;
        logic [SIZE_W-1:0] header_size;
        logic [WORD_W-1:0] header_crc;
    } result_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_FINISH
    } ctrl_state_t;

    // Reflected CRC-32 update of one byte, zlib convention.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = (crc ^ CRC_XOR) ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c ^ CRC_XOR;
    endfunction

endpackage

>>> hdl/fiw_ctrl.sv
// ----------------------------------------------------------------------------
// Flash image writer controller
// Handshake control and sequencing of the remainder division for begin items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fiw_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output fiw_pkg::dp_cmd_t   cmd,
    input  fiw_pkg::dp_status_t stat
);

    fiw_pkg::ctrl_state_t state_reg;
    fiw_pkg::ctrl_state_t state_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fiw_pkg::S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg && !result_ready;
        cmd          = '0;
        item_ready   = 1'b0;
        accept       = 1'b0;
        case (state_reg)
            fiw_pkg::S_IDLE:
            begin
                item_ready = !valid_reg || result_ready;
                accept     = item_ready && item_valid;
                cmd.load   = accept;
                if (accept)
                begin
                    if (stat.need_div)
                    begin
                        state_next = fiw_pkg::S_DIVIDE;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                    end
                end
            end
            fiw_pkg::S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = fiw_pkg::S_FINISH;
                end
            end
            fiw_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                valid_next = 1'b1;
                state_next = fiw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fiw_pkg::S_IDLE;
            end
        endcase
    end

    assign result_valid = valid_reg;

endmodule

>>> hdl/fiw_dpath.sv
// ----------------------------------------------------------------------------
// Flash image writer datapath
// Configuration and writer state, remainder divider, CRC and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fiw_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fiw_pkg::item_t                    item,
    input  logic                              wr_en,
    input  logic [fiw_pkg::INDEX_W-1:0]       wr_index,
    input  logic [fiw_pkg::WORD_W-1:0]        wr_data,
    input  fiw_pkg::dp_cmd_t                  cmd,
    output fiw_pkg::dp_status_t               stat,
    output fiw_pkg::result_t                  result
);

    logic [fiw_pkg::SIZE_W-1:0] flash_size_reg;
    logic [fiw_pkg::UNIT_W-1:0] sector_size_reg;
    logic [fiw_pkg::WORD_W-1:0] magic_reg;

    logic                       is_open_reg,       is_open_next;
    logic [fiw_pkg::SIZE_W-1:0] declared_size_reg, declared_size_next;
    logic [fiw_pkg::SIZE_W-1:0] written_count_reg, written_count_next;
    logic [fiw_pkg::WORD_W-1:0] running_crc_reg,   running_crc_next;

    logic [fiw_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                       fail_reg, fail_next;
    logic [fiw_pkg::UNIT_W-1:0] rem_reg,  rem_next;
    logic [fiw_pkg::CNT_W-1:0]  cnt_reg,  cnt_next;
    fiw_pkg::result_t           result_reg, result_next;

    fiw_pkg::result_t           imm;
    fiw_pkg::result_t           fin;
    logic                       args_bad;
    logic                       need_div;
    logic [fiw_pkg::UNIT_W:0]   trial;
    logic [fiw_pkg::SIZE_W:0]   len_rnd;
    logic [fiw_pkg::SIZE_W-1:0] room;
    logic [fiw_pkg::SIZE_W:0]   len_total;
    logic [fiw_pkg::SIZE_W-1:0] unit_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_size_reg    <= fiw_pkg::FLASH_SIZE_RST;
            sector_size_reg   <= fiw_pkg::SECTOR_SIZE_RST;
            magic_reg         <= '0;
            is_open_reg       <= 1'b0;
            declared_size_reg <= '0;
            written_count_reg <= '0;
            running_crc_reg   <= '0;
        end
        else
        begin
            if (wr_en && wr_index == fiw_pkg::REG_FLASH_SIZE)
            begin
                flash_size_reg <= wr_data[fiw_pkg::SIZE_W-1:0];
            end
            if (wr_en && wr_index == fiw_pkg::REG_SECTOR_SIZE)
            begin
                sector_size_reg <= wr_data[fiw_pkg::UNIT_W-1:0];
            end
            if (wr_en && wr_index == fiw_pkg::REG_MAGIC)
            begin
                magic_reg <= wr_data;
            end
            is_open_reg       <= is_open_next;
            declared_size_reg <= declared_size_next;
            written_count_reg <= written_count_next;
            running_crc_reg   <= running_crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        fail_reg   <= fail_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign unit_ext = {{(fiw_pkg::SIZE_W-fiw_pkg::UNIT_W){1'b0}}, sector_size_reg};
    assign args_bad = (sector_size_reg == '0) || (flash_size_reg < unit_ext)
                      || (item.image_size == '0);

    // Restoring division step; only the remainder is kept.
    assign trial = {rem_reg, size_reg[cnt_reg]};

    // Round up to whole sectors, then add the header sector.
    assign len_rnd   = (rem_reg == '0) ? {1'b0, size_reg}
                     : {1'b0, size_reg} + {1'b0, unit_ext}
                       - {{(fiw_pkg::SIZE_W+1-fiw_pkg::UNIT_W){1'b0}}, rem_reg};
    assign room      = flash_size_reg - unit_ext;
    assign len_total = len_rnd + {1'b0, unit_ext};

    always_comb
    begin
        is_open_next       = is_open_reg;
        declared_size_next = declared_size_reg;
        written_count_next = written_count_reg;
        running_crc_next   = running_crc_reg;
        size_next          = size_reg;
        fail_next          = fail_reg;
        rem_next           = rem_reg;
        cnt_next           = cnt_reg;
        result_next        = result_reg;
        imm                = '0;
        fin                = '0;
        need_div           = 1'b0;

        case (item.mode)
            fiw_pkg::MODE_BEGIN:
            begin
                if (args_bad)
                begin
                    imm.status = fiw_pkg::ST_ARGS;
                end
                else
                begin
                    need_div = 1'b1;
                end
            end
            fiw_pkg::MODE_DATA:
            begin
                if (!is_open_reg)
                begin
                    imm.status = fiw_pkg::ST_ORDER;
                end
                else if (written_count_reg >= declared_size_reg)
                begin
                    imm.status = fiw_pkg::ST_RANGE;
                end
                else
                begin
                    imm.flash_op      = fiw_pkg::OP_WRITE;
                    imm.flash_address = unit_ext + written_count_reg;
                    imm.write_byte    = item.data_byte;
                    imm.status        = item.io_failed ? fiw_pkg::ST_IO : fiw_pkg::ST_OK;
                end
            end
            fiw_pkg::MODE_END:
            begin
                if (!is_open_reg || written_count_reg != declared_size_reg)
                begin
                    imm.status = fiw_pkg::ST_ORDER;
                end
                else
                begin
                    imm.flash_op     = fiw_pkg::OP_HEADER;
                    imm.header_magic = magic_reg;
                    imm.header_size  = declared_size_reg;
                    imm.header_crc   = running_crc_reg;
                    imm.status       = item.io_failed ? fiw_pkg::ST_IO : fiw_pkg::ST_OK;
                end
            end
            default:
            begin
                imm.status = fiw_pkg::ST_ARGS;
            end
        endcase

        if (len_rnd > {1'b0, room})
        begin
            fin.status = fiw_pkg::ST_RANGE;
        end
        else
        begin
            fin.flash_op     = fiw_pkg::OP_ERASE;
            fin.erase_length = len_total[fiw_pkg::SIZE_W-1:0];
            fin.status       = fail_reg ? fiw_pkg::ST_IO : fiw_pkg::ST_OK;
        end

        if (cmd.load)
        begin
            if (need_div)
            begin
                size_next = item.image_size;
                fail_next = item.io_failed;
                rem_next  = '0;
                cnt_next  = fiw_pkg::CNT_W'(fiw_pkg::SIZE_W - 1);
            end
            else
            begin
                result_next = imm;
                if (item.mode == fiw_pkg::MODE_DATA && imm.flash_op == fiw_pkg::OP_WRITE
                    && !item.io_failed)
                begin
                    running_crc_next   = fiw_pkg::crc_byte(running_crc_reg, item.data_byte);
                    written_count_next = written_count_reg + 1'b1;
                end
                if (item.mode == fiw_pkg::MODE_END)
                begin
                    is_open_next = 1'b0;
                end
            end
        end

        if (cmd.div_step)
        begin
            if (trial >= {1'b0, sector_size_reg})
            begin
                rem_next = fiw_pkg::UNIT_W'(trial - {1'b0, sector_size_reg});
            end
            else
            begin
                rem_next = trial[fiw_pkg::UNIT_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.finish)
        begin
            result_next = fin;
            if (fin.flash_op == fiw_pkg::OP_ERASE)
            begin
                is_open_next       = !fail_reg;
                declared_size_next = fail_reg ? '0 : size_reg;
                written_count_next = '0;
                running_crc_next   = '0;
            end
        end
    end

    assign stat.need_div = need_div;
    assign stat.div_last = (cnt_reg == '0);
    assign result        = result_reg;

endmodule

>>> hdl/flash_image_writer_crc.sv
// ----------------------------------------------------------------------------
// Flash image writer with CRC-32
// Sequences the erase, byte writes and header write of one image in a flash
// partition, keeping a reflected CRC-32 of the image bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   ------------------------------
//  item      item_valid / item_ready        item   (fiw_pkg::item_t)
//  result    result_valid / result_ready    result (fiw_pkg::result_t)
//  config    wr_en (no wait)                wr_index, wr_data
//
// Data bytes, end items, rejected begin items and mode 3 items are answered
// directly. A valid begin item is captured, then runs the remainder division
// by the erase sector size (one bit per cycle, 18-bit subtractor), then is
// rounded, range-checked and turned into the erase. A new item is taken in the
// cycle its predecessor's result transfer completes; a stalled result holds
// off further items. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flash_image_writer_crc
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  fiw_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output fiw_pkg::result_t              result,
    input  logic                          wr_en,
    input  logic [fiw_pkg::INDEX_W-1:0]   wr_index,
    input  logic [fiw_pkg::WORD_W-1:0]    wr_data
);

    // Commands from the controller and status back from the datapath.
    fiw_pkg::dp_cmd_t    cmd;
    fiw_pkg::dp_status_t stat;

    // The controller owns the handshakes and the begin sequencing.
    fiw_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // The datapath holds configuration, writer state and the result register.
    fiw_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    // A result that commands no flash operation is never reported as success.
    `ASSERT_SAME(a_noop_not_ok, clk, rst_n,
        result_valid && result.flash_op == fiw_pkg::OP_NONE,
        result.status != fiw_pkg::ST_OK)

    // The erase length only travels with an erase command.
    `ASSERT_SAME(a_len_only_erase, clk, rst_n,
        result_valid && result.flash_op != fiw_pkg::OP_ERASE,
        result.erase_length == '0)

    // While the divider runs, no earlier result may still be waiting.
    `ASSERT_SAME(a_div_no_result, clk, rst_n, cmd.div_step, !result_valid && !item_ready)

    // Finishing a begin item always presents a result on the next cycle.
    `ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, result_valid)

endmodule
